### rtl/spr_pkg.sv
package spr_pkg;

    // Fixed field widths
    localparam int CORR_BITS = 16;
    localparam int FRAC_BITS = 8;
    localparam int MAX_CHIP  = 255;
    localparam int DISP_BITS = 17;
    localparam int POS_BITS  = 9;
    localparam int CFG_BITS  = 8;

    // Fit arithmetic widths
    localparam int EW  = 20;                 // second differences E, F
    localparam int AW  = 19;                 // first differences A, Bd
    localparam int DW  = 18;                 // cross term D
    localparam int PW  = 40;                 // products
    localparam int GW  = 44;                 // G and numerators, signed
    localparam int MW  = GW - 1;             // magnitudes
    localparam int RW  = 54;                 // divider remainder
    localparam int QW  = FRAC_BITS;          // quotient bits
    localparam int BW  = 10;                 // integer shift, signed

    // Register indexes
    localparam logic [1:0] CFG_MASTER_W = 2'd0;
    localparam logic [1:0] CFG_MASTER_H = 2'd1;
    localparam logic [1:0] CFG_SEARCH_W = 2'd2;
    localparam logic [1:0] CFG_SEARCH_H = 2'd3;

    typedef struct packed {
        logic [CFG_BITS-1:0] mw;
        logic [CFG_BITS-1:0] mh;
        logic [CFG_BITS-1:0] sw;
        logic [CFG_BITS-1:0] sh;
    } t_cfg;

    // Fields that ride alongside the arithmetic
    typedef struct packed {
        logic signed [BW-1:0]        bx;
        logic signed [BW-1:0]        by;
        logic signed [CORR_BITS-1:0] corr;
        logic                        ok;
    } t_side;

    // Beat handed to and through the divider
    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [RW-1:0] den;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        logic          neg_x;
        logic          neg_y;
        logic          refined;
        t_side         side;
    } t_div;

    // Chip size with zero taken as one and clamp to the maximum
    function automatic logic [CFG_BITS-1:0] chip_sz(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS-1:0] r;
        r = v;
        if (v == '0) r = CFG_BITS'(1);
        else if (32'(v) > MAX_CHIP) r = CFG_BITS'(MAX_CHIP);
        return r;
    endfunction

endpackage

### rtl/spr_in_if.sv
interface spr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [spr_pkg::POS_BITS-1:0]         peak_col;
    logic [spr_pkg::POS_BITS-1:0]         peak_row;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_nw;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_n;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_ne;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_w;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_c;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_e;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_sw;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_s;
    logic signed [spr_pkg::CORR_BITS-1:0] corr_se;
    logic                                 corr_ok;

    modport source (output valid, peak_col, peak_row, corr_nw, corr_n, corr_ne, corr_w,
                    corr_c, corr_e, corr_sw, corr_s, corr_se, corr_ok, input ready);
    modport sink   (input valid, peak_col, peak_row, corr_nw, corr_n, corr_ne, corr_w,
                    corr_c, corr_e, corr_sw, corr_s, corr_se, corr_ok, output ready);
endinterface

### rtl/spr_out_if.sv
interface spr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spr_pkg::DISP_BITS-1:0] disp_x;
    logic signed [spr_pkg::DISP_BITS-1:0] disp_y;
    logic signed [spr_pkg::CORR_BITS-1:0] best_corr;
    logic                                 refined;

    modport source (output valid, disp_x, disp_y, best_corr, refined, input ready);
    modport sink   (input valid, disp_x, disp_y, best_corr, refined, output ready);
endinterface

### rtl/spr_fit.sv
// Quadratic surface fit: sums, products, G and numerators, acceptance test.
// Five register stages, each with its own valid bit.
module spr_fit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spr_pkg::t_cfg   i_cfg,
    spr_in_if.sink          i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output spr_pkg::t_div   o_div
);

    localparam int NS = 5;

    logic [NS:1]   r_vld;
    logic [NS+1:1] en;

    // Stage enables ripple back from the sink
    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign i_item.ready = en[1];
    assign o_valid      = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_item.valid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---- stage 1: window test, row and column sums ----
    logic [spr_pkg::CFG_BITS-1:0] mw, mh, sw, sh;
    logic [spr_pkg::CFG_BITS:0]   sum_w, sum_h;
    logic signed [10:0]           ox, oy, dx, dy, mj, mi;
    logic                         win;
    logic signed [17:0]           cl, cc, cr, rt, rm, rb;
    logic signed [spr_pkg::AW-1:0] n_a, n_bd;
    logic signed [spr_pkg::DW-1:0] n_d;
    logic signed [spr_pkg::EW-1:0] n_e, n_f;
    spr_pkg::t_side               n_side1;

    assign mw = spr_pkg::chip_sz(i_cfg.mw);
    assign mh = spr_pkg::chip_sz(i_cfg.mh);
    assign sw = spr_pkg::chip_sz(i_cfg.sw);
    assign sh = spr_pkg::chip_sz(i_cfg.sh);
    assign sum_w = ({1'b0, sw} + {1'b0, mw} - 9'd2) >> 1;
    assign sum_h = ({1'b0, sh} + {1'b0, mh} - 9'd2) >> 1;
    assign ox = $signed({2'b0, sum_w});
    assign oy = $signed({2'b0, sum_h});
    assign dx = (sw > mw) ? $signed({3'b0, 8'((sw - mw) >> 1)}) : 11'sd0;
    assign dy = (sh > mh) ? $signed({3'b0, 8'((sh - mh) >> 1)}) : 11'sd0;
    assign mj = $signed({2'b0, i_item.peak_col});
    assign mi = $signed({2'b0, i_item.peak_row});
    assign win = (mj > ox - dx) && (mj < ox + dx) && (mi > oy - dy) && (mi < oy + dy);

    assign cl = 18'(i_item.corr_nw) + 18'(i_item.corr_w) + 18'(i_item.corr_sw);
    assign cc = 18'(i_item.corr_n)  + 18'(i_item.corr_c) + 18'(i_item.corr_s);
    assign cr = 18'(i_item.corr_ne) + 18'(i_item.corr_e) + 18'(i_item.corr_se);
    assign rt = 18'(i_item.corr_nw) + 18'(i_item.corr_n) + 18'(i_item.corr_ne);
    assign rm = 18'(i_item.corr_w)  + 18'(i_item.corr_c) + 18'(i_item.corr_e);
    assign rb = 18'(i_item.corr_sw) + 18'(i_item.corr_s) + 18'(i_item.corr_se);
    assign n_a  = 19'(cr) - 19'(cl);
    assign n_bd = 19'(rb) - 19'(rt);
    assign n_d  = 18'(i_item.corr_nw) - 18'(i_item.corr_ne) - 18'(i_item.corr_sw)
                + 18'(i_item.corr_se);
    assign n_e  = 20'(cl) + 20'(cr) - (20'(cc) <<< 1);
    assign n_f  = 20'(rt) + 20'(rb) - (20'(rm) <<< 1);

    assign n_side1.bx   = 10'(mj - ox);
    assign n_side1.by   = 10'(mi - oy);
    assign n_side1.corr = i_item.corr_c;
    assign n_side1.ok   = i_item.corr_ok;

    logic signed [spr_pkg::AW-1:0] r1_a, r1_bd;
    logic signed [spr_pkg::DW-1:0] r1_d;
    logic signed [spr_pkg::EW-1:0] r1_e, r1_f;
    logic                          r1_win;
    spr_pkg::t_side                r1_side;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_a    <= n_a;
            r1_bd   <= n_bd;
            r1_d    <= n_d;
            r1_e    <= n_e;
            r1_f    <= n_f;
            r1_win  <= win;
            r1_side <= n_side1;
        end
    end

    // ---- stage 2: six products, trace sign ----
    logic signed [spr_pkg::PW-1:0] n_ef, n_dd, n_dbd, n_fa, n_da, n_ebd;
    logic signed [spr_pkg::EW:0]   n_tr;

    assign n_ef  = r1_e * r1_f;
    assign n_dd  = r1_d * r1_d;
    assign n_dbd = r1_d * r1_bd;
    assign n_fa  = r1_f * r1_a;
    assign n_da  = r1_d * r1_a;
    assign n_ebd = r1_e * r1_bd;
    assign n_tr  = 21'(r1_e) + 21'(r1_f);

    logic signed [spr_pkg::PW-1:0] r2_ef, r2_dd, r2_dbd, r2_fa, r2_da, r2_ebd;
    logic                          r2_cond;
    spr_pkg::t_side                r2_side;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_ef   <= n_ef;
            r2_dd   <= n_dd;
            r2_dbd  <= n_dbd;
            r2_fa   <= n_fa;
            r2_da   <= n_da;
            r2_ebd  <= n_ebd;
            r2_cond <= r1_win && n_tr[spr_pkg::EW];
            r2_side <= r1_side;
        end
    end

    // ---- stage 3: determinant term G and the two numerators ----
    logic signed [spr_pkg::GW-1:0] n_g, n_nx, n_ny;

    assign n_g  = (44'(r2_ef) <<< 4) - (44'(r2_dd) <<< 3) - 44'(r2_dd);
    assign n_nx = (44'(r2_dbd) <<< 2) + (44'(r2_dbd) <<< 1) - (44'(r2_fa) <<< 3);
    assign n_ny = (44'(r2_da) <<< 2) + (44'(r2_da) <<< 1) - (44'(r2_ebd) <<< 3);

    logic signed [spr_pkg::GW-1:0] r3_g, r3_nx, r3_ny;
    logic                          r3_cond;
    spr_pkg::t_side                r3_side;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_g    <= n_g;
            r3_nx   <= n_nx;
            r3_ny   <= n_ny;
            r3_cond <= r2_cond;
            r3_side <= r2_side;
        end
    end

    // ---- stage 4: magnitudes and sign of G ----
    logic [spr_pkg::GW-1:0] abs_x, abs_y;
    assign abs_x = r3_nx[spr_pkg::GW-1] ? 44'(-r3_nx) : 44'(r3_nx);
    assign abs_y = r3_ny[spr_pkg::GW-1] ? 44'(-r3_ny) : 44'(r3_ny);

    logic [spr_pkg::MW-1:0] r4_ax, r4_ay, r4_g;
    logic                   r4_cond, r4_neg_x, r4_neg_y;
    spr_pkg::t_side         r4_side;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_ax    <= abs_x[spr_pkg::MW-1:0];
            r4_ay    <= abs_y[spr_pkg::MW-1:0];
            r4_g     <= r3_g[spr_pkg::MW-1:0];
            r4_cond  <= r3_cond && !r3_g[spr_pkg::GW-1] && (r3_g != '0);
            r4_neg_x <= r3_nx[spr_pkg::GW-1];
            r4_neg_y <= r3_ny[spr_pkg::GW-1];
            r4_side  <= r3_side;
        end
    end

    // ---- stage 5: 0.501 bound, rounded dividend and divisor ----
    logic [spr_pkg::RW-1:0] k_ax, k_ay, k_g;
    spr_pkg::t_div          n_div;

    assign k_ax = spr_pkg::RW'(r4_ax) * spr_pkg::RW'(1000);
    assign k_ay = spr_pkg::RW'(r4_ay) * spr_pkg::RW'(1000);
    assign k_g  = spr_pkg::RW'(r4_g)  * spr_pkg::RW'(501);

    always_comb begin
        n_div         = '0;
        n_div.rem_x   = (spr_pkg::RW'(r4_ax) << (spr_pkg::FRAC_BITS + 1))
                      + spr_pkg::RW'(r4_g);
        n_div.rem_y   = (spr_pkg::RW'(r4_ay) << (spr_pkg::FRAC_BITS + 1))
                      + spr_pkg::RW'(r4_g);
        n_div.den     = spr_pkg::RW'(r4_g) << 1;
        n_div.neg_x   = r4_neg_x;
        n_div.neg_y   = r4_neg_y;
        n_div.refined = r4_cond && (k_ax <= k_g) && (k_ay <= k_g);
        n_div.side    = r4_side;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) o_div <= n_div;
    end

endmodule

### rtl/spr_div.sv
// Restoring divider for both offsets, one quotient bit per stage.
module spr_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spr_pkg::t_div  i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output spr_pkg::t_div  o_div
);

    localparam int NS = spr_pkg::QW;

    logic [NS-1:0]  r_vld;
    logic [NS:0]    en;
    spr_pkg::t_div  r_st [NS];
    spr_pkg::t_div  n_st [NS];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_div   = r_st[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            spr_pkg::t_div          cur;
            logic [spr_pkg::RW-1:0] sub;

            if (j == 0) begin : g_first
                assign cur = i_div;
            end else begin : g_next
                assign cur = r_st[j-1];
            end

            // trial subtract of the divisor at this bit weight
            assign sub = cur.den << (NS - 1 - j);
            always_comb begin
                n_st[j] = cur;
                if (cur.rem_x >= sub) begin
                    n_st[j].rem_x           = cur.rem_x - sub;
                    n_st[j].q_x[NS - 1 - j] = 1'b1;
                end
                if (cur.rem_y >= sub) begin
                    n_st[j].rem_y           = cur.rem_y - sub;
                    n_st[j].q_y[NS - 1 - j] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[j]) r_st[j] <= n_st[j];
            end
        end
    endgenerate

endmodule

### rtl/ncc_subpixel_peak_refine_top.sv
// Pipeline: an accepted input beat passes 5 fit stages, 8 divider stages and
//   1 output register before its result beat.
// Throughput: one beat per cycle; each stage stalls only while full and blocked.
// Reset: synchronous, active low; clears all valid bits and loads the chip
//   sizes 11, 11, 25, 25. No clearing pass.
module ncc_subpixel_peak_refine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [spr_pkg::CFG_BITS-1:0]  i_cfg_data,
    spr_in_if.sink                        i_item,
    spr_out_if.source                     o_res
);

    // Configuration registers
    spr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mw <= 8'd11;
            r_cfg.mh <= 8'd11;
            r_cfg.sw <= 8'd25;
            r_cfg.sh <= 8'd25;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spr_pkg::CFG_MASTER_W: r_cfg.mw <= i_cfg_data;
                spr_pkg::CFG_MASTER_H: r_cfg.mh <= i_cfg_data;
                spr_pkg::CFG_SEARCH_W: r_cfg.sw <= i_cfg_data;
                spr_pkg::CFG_SEARCH_H: r_cfg.sh <= i_cfg_data;
                default:               r_cfg    <= r_cfg;
            endcase
        end
    end

    // Fit and divider
    logic          fit_vld, div_rdy, div_vld, fin_en;
    spr_pkg::t_div fit_div, div_out;

    spr_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_valid (fit_vld),
        .i_ready (div_rdy),
        .o_div   (fit_div)
    );

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fit_vld),
        .o_ready (div_rdy),
        .i_div   (fit_div),
        .o_valid (div_vld),
        .i_ready (fin_en),
        .o_div   (div_out)
    );

    // Final: add offset to integer shift, saturate, zero on failure
    localparam int SW = spr_pkg::BW + spr_pkg::FRAC_BITS + 2;

    logic signed [SW-1:0] sum_x, sum_y, off_x, off_y;
    logic signed [spr_pkg::DISP_BITS-1:0] n_dx, n_dy;

    function automatic logic signed [spr_pkg::DISP_BITS-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [spr_pkg::DISP_BITS-1:0] r;
        r = spr_pkg::DISP_BITS'(v);
        if (v > SW'(2**(spr_pkg::DISP_BITS-1) - 1)) r = {1'b0, {(spr_pkg::DISP_BITS-1){1'b1}}};
        else if (v < -SW'(2**(spr_pkg::DISP_BITS-1))) r = {1'b1, {(spr_pkg::DISP_BITS-1){1'b0}}};
        return r;
    endfunction

    always_comb begin
        off_x = '0;
        off_y = '0;
        if (div_out.refined) begin
            off_x = div_out.neg_x ? -$signed(SW'(div_out.q_x)) : $signed(SW'(div_out.q_x));
            off_y = div_out.neg_y ? -$signed(SW'(div_out.q_y)) : $signed(SW'(div_out.q_y));
        end
        sum_x = (SW'(div_out.side.bx) <<< spr_pkg::FRAC_BITS) + off_x;
        sum_y = (SW'(div_out.side.by) <<< spr_pkg::FRAC_BITS) + off_y;
        n_dx  = sat(sum_x);
        n_dy  = sat(sum_y);
    end

    logic r_ovld;
    assign fin_en      = !r_ovld || o_res.ready;
    assign o_res.valid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (fin_en) begin
            r_ovld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_en) begin
            o_res.disp_x    <= div_out.side.ok ? n_dx : '0;
            o_res.disp_y    <= div_out.side.ok ? n_dy : '0;
            o_res.best_corr <= div_out.side.ok ? div_out.side.corr : '0;
            o_res.refined   <= div_out.side.ok && div_out.refined;
        end
    end

    // An empty output register must leave the whole pipeline open
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> i_item.ready)
        else $error("input blocked with empty output register");

    // Without refinement the shift is a whole number of pixels
    a_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !o_res.refined && o_res.disp_x != {1'b0, {(spr_pkg::DISP_BITS-1){1'b1}}}
        |-> o_res.disp_x[spr_pkg::FRAC_BITS-1:0] == '0)
        else $error("fractional shift without refinement");

    // A held result beat with zero best_corr and nonzero disp_x never carries an unknown refined flag
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && o_res.best_corr == '0 && o_res.disp_x != '0 |-> !$isunknown(o_res.refined))
        else $error("unknown refined flag");

endmodule

### dv/tb_ncc_subpixel_peak_refine_top.sv
module tb_ncc_subpixel_peak_refine_top;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [spr_pkg::CFG_BITS-1:0] i_cfg_data;

    spr_in_if  item_ch ();
    spr_out_if res_ch ();

    ncc_subpixel_peak_refine_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_res      (res_ch.source)
    );

    typedef struct {
        logic [spr_pkg::POS_BITS-1:0] col;
        logic [spr_pkg::POS_BITS-1:0] row;
        logic signed [spr_pkg::CORR_BITS-1:0] v[9];
        logic ok;
    } t_peak;

    typedef struct {
        logic signed [spr_pkg::DISP_BITS-1:0] dx;
        logic signed [spr_pkg::DISP_BITS-1:0] dy;
        logic signed [spr_pkg::CORR_BITS-1:0] corr;
        logic refined;
    } t_disp;

    // Directed row: stimulus plus optional typed-in result
    typedef struct {
        t_peak pk;
        bit    has_exp;
        t_disp exp;
    } t_row;

    logic [spr_pkg::CFG_BITS-1:0] reg_mw, reg_mh, reg_sw, reg_sh;
    t_disp disp_queue[$];
    int    fail_cnt = 0;
    int    send_idle_pct, recv_stall_pct;
    bit    hold_off;
    longint cycle_cnt = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Append an expected beat to the scoreboard
    function automatic void put_disp(input t_disp d);
        disp_queue.insert(disp_queue.size(), d);
    endfunction

    function automatic logic [spr_pkg::CFG_BITS-1:0] clamp_chip(
        input logic [spr_pkg::CFG_BITS-1:0] v);
        return (v == 0) ? spr_pkg::CFG_BITS'(1) : v;
    endfunction

    // Round-to-nearest offset in 1/256 pixel, ties away from zero
    function automatic longint frac_offset(input longint num, input longint den);
        longint a, q;
        a = (num < 0) ? -num : num;
        q = (2 * (a << spr_pkg::FRAC_BITS) + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [spr_pkg::DISP_BITS-1:0] clip_disp(input longint v);
        if (v < -65536) v = -65536;
        if (v > 65535) v = 65535;
        return spr_pkg::DISP_BITS'(v);
    endfunction

    // Quadratic surface fit of the 3x3 neighbourhood
    function automatic t_disp refine_peak(input t_peak pk);
        t_disp r;
        longint w[9];
        longint mw, mh, sw, sh, ox, oy, hx, hy, px, py, bx, by;
        longint cl, cc, cr, rt, rm, rb, a, bd, d, e, f, g, nx, ny, ax, ay;
        r.refined = 1'b0;
        if (!pk.ok) begin
            r.dx = '0; r.dy = '0; r.corr = '0;
            return r;
        end
        for (int k = 0; k < 9; k++) w[k] = pk.v[k];
        mw = clamp_chip(reg_mw); mh = clamp_chip(reg_mh);
        sw = clamp_chip(reg_sw); sh = clamp_chip(reg_sh);
        px = pk.col; py = pk.row;
        ox = (sw + mw - 2) >>> 1;
        oy = (sh + mh - 2) >>> 1;
        hx = (sw > mw) ? (sw - mw) >>> 1 : 0;
        hy = (sh > mh) ? (sh - mh) >>> 1 : 0;
        bx = (px - ox) * 256;
        by = (py - oy) * 256;
        if (px > ox - hx && px < ox + hx && py > oy - hy && py < oy + hy) begin
            cl = w[0] + w[3] + w[6]; cc = w[1] + w[4] + w[7]; cr = w[2] + w[5] + w[8];
            rt = w[0] + w[1] + w[2]; rm = w[3] + w[4] + w[5]; rb = w[6] + w[7] + w[8];
            a = cr - cl; bd = rb - rt;
            d = w[0] - w[2] - w[6] + w[8];
            e = cl + cr - 2 * cc; f = rt + rb - 2 * rm;
            g = 16 * e * f - 9 * d * d;
            if (e + f < 0 && g > 0) begin
                nx = 6 * d * bd - 8 * f * a;
                ny = 6 * d * a - 8 * e * bd;
                ax = (nx < 0) ? -nx : nx;
                ay = (ny < 0) ? -ny : ny;
                if (1000 * ax <= 501 * g && 1000 * ay <= 501 * g) begin
                    bx += frac_offset(nx, g);
                    by += frac_offset(ny, g);
                    r.refined = 1'b1;
                end
            end
        end
        r.dx = clip_disp(bx);
        r.dy = clip_disp(by);
        r.corr = pk.v[4];
        return r;
    endfunction

    // One register write; the enable is dropped by the caller
    task automatic write_reg(input logic [1:0] idx, input logic [spr_pkg::CFG_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            spr_pkg::CFG_MASTER_W: reg_mw = val;
            spr_pkg::CFG_MASTER_H: reg_mh = val;
            spr_pkg::CFG_SEARCH_W: reg_sw = val;
            default:               reg_sh = val;
        endcase
    endtask

    task automatic set_chips(input int mw, input int mh, input int sw, input int sh);
        write_reg(spr_pkg::CFG_MASTER_W, spr_pkg::CFG_BITS'(mw));
        write_reg(spr_pkg::CFG_MASTER_H, spr_pkg::CFG_BITS'(mh));
        write_reg(spr_pkg::CFG_SEARCH_W, spr_pkg::CFG_BITS'(sw));
        write_reg(spr_pkg::CFG_SEARCH_H, spr_pkg::CFG_BITS'(sh));
        i_cfg_we <= 1'b0;
    endtask

    // Block idle: queue drained plus pipeline latency
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (disp_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Offer one beat at the falling edge, hold until accepted
    task automatic send_peak(input t_peak pk, input bit has_exp, input t_disp exp);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.peak_col <= pk.col;
        item_ch.peak_row <= pk.row;
        item_ch.corr_nw  <= pk.v[0];
        item_ch.corr_n   <= pk.v[1];
        item_ch.corr_ne  <= pk.v[2];
        item_ch.corr_w   <= pk.v[3];
        item_ch.corr_c   <= pk.v[4];
        item_ch.corr_e   <= pk.v[5];
        item_ch.corr_sw  <= pk.v[6];
        item_ch.corr_s   <= pk.v[7];
        item_ch.corr_se  <= pk.v[8];
        item_ch.corr_ok  <= pk.ok;
        do @(posedge i_clk); while (!item_ch.ready);
        put_disp(has_exp ? exp : refine_peak(pk));
        @(negedge i_clk);
    endtask

    // Concave surface near the centre with random skew and amplitude, or random data if not well formed
    function automatic t_peak gen_peak(input bit well_formed);
        t_peak pk;
        int amp, cx, cy, ox, oy, hx, hy;
        pk.ok = ($urandom_range(19) != 0);
        if (well_formed) begin
            ox = (clamp_chip(reg_sw) + clamp_chip(reg_mw) - 2) / 2;
            oy = (clamp_chip(reg_sh) + clamp_chip(reg_mh) - 2) / 2;
            hx = (reg_sw > reg_mw) ? (reg_sw - reg_mw) / 2 : 0;
            hy = (reg_sh > reg_mh) ? (reg_sh - reg_mh) / 2 : 0;
            pk.col = spr_pkg::POS_BITS'(ox - hx + $urandom_range(2 * hx));
            pk.row = spr_pkg::POS_BITS'(oy - hy + $urandom_range(2 * hy));
            amp = $urandom_range(16000, 1);
            cx = $urandom_range(200) - 100;
            cy = $urandom_range(200) - 100;
            for (int k = 0; k < 9; k++) begin
                int x, y, s;
                x = k % 3 - 1; y = k / 3 - 1;
                s = 30000 - amp * (x * x + y * y) / 2 + cx * x * amp / 200
                    + cy * y * amp / 200 + $signed($urandom_range(400)) - 200;
                if (s > 32767) s = 32767;
                if (s < -32768) s = -32768;
                pk.v[k] = spr_pkg::CORR_BITS'(s);
            end
        end else begin
            pk.col = spr_pkg::POS_BITS'($urandom);
            pk.row = spr_pkg::POS_BITS'($urandom);
            for (int k = 0; k < 9; k++) pk.v[k] = spr_pkg::CORR_BITS'($urandom);
        end
        return pk;
    endfunction

    // Result side: stalls, long hold-off, and checking
    always @(negedge i_clk) begin
        res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_disp want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (disp_queue.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                want = disp_queue.pop_front();
                if (res_ch.disp_x !== want.dx) begin
                    $error("disp_x exp %0d got %0d", want.dx, res_ch.disp_x);
                    fail_cnt++;
                end
                if (res_ch.disp_y !== want.dy) begin
                    $error("disp_y exp %0d got %0d", want.dy, res_ch.disp_y);
                    fail_cnt++;
                end
                if (res_ch.best_corr !== want.corr) begin
                    $error("best_corr exp %0d got %0d", want.corr, res_ch.best_corr);
                    fail_cnt++;
                end
                if (res_ch.refined !== want.refined) begin
                    $error("refined exp %0d got %0d", want.refined, res_ch.refined);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        t_row  rows[$];
        t_row  r;
        t_disp none;
        int    phase_idle[4];
        int    phase_stall[4];
        phase_idle = '{0, 60, 0, 12};
        phase_stall = '{0, 0, 60, 12};
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        none = '{default: '0};
        reg_mw = 11; reg_mh = 11; reg_sw = 25; reg_sh = 25;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = spr_pkg::CFG_MASTER_W;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.peak_col = '0;
        item_ch.peak_row = '0;
        item_ch.corr_nw = '0; item_ch.corr_n = '0; item_ch.corr_ne = '0;
        item_ch.corr_w = '0;  item_ch.corr_c = '0; item_ch.corr_e = '0;
        item_ch.corr_sw = '0; item_ch.corr_s = '0; item_ch.corr_se = '0;
        item_ch.corr_ok = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table under reset sizes (centre 17, margin 7)
        r.has_exp = 1'b1;
        r.pk.ok = 1'b0; r.pk.col = '1; r.pk.row = '1;
        foreach (r.pk.v[k]) r.pk.v[k] = -16'sd1;
        r.exp = none;
        rows.insert(rows.size(), r);
        // flat surface at centre: no refinement, zero shift
        r.pk.ok = 1'b1; r.pk.col = 9'd17; r.pk.row = 9'd17;
        foreach (r.pk.v[k]) r.pk.v[k] = 16'sh7fff;
        r.exp = '{dx: 0, dy: 0, corr: 16'sh7fff, refined: 0};
        rows.insert(rows.size(), r);
        // outside margin corner extremes
        r.pk.col = 9'd0; r.pk.row = 9'd0;
        foreach (r.pk.v[k]) r.pk.v[k] = 16'sh8000;
        r.exp = '{dx: -17 * 256, dy: -17 * 256, corr: 16'sh8000, refined: 0};
        rows.insert(rows.size(), r);
        // far corner saturates to the largest displacement
        r.pk.col = 9'd511; r.pk.row = 9'd511;
        r.exp = '{dx: 65535, dy: 65535, corr: 16'sh8000, refined: 0};
        rows.insert(rows.size(), r);
        // margin edges and near-symmetric peaks
        r.has_exp = 1'b0;
        for (int j = 0; j < 6; j++) begin
            r.pk.col = (j < 3) ? spr_pkg::POS_BITS'(10 + j * 7) : 9'd17;
            r.pk.row = (j < 3) ? 9'd17 : spr_pkg::POS_BITS'(10 + (j - 3) * 7);
            foreach (r.pk.v[k])
                r.pk.v[k] = (k == 4) ? 16'sd30000 : spr_pkg::CORR_BITS'(20000 - k);
            rows.insert(rows.size(), r);
        end
        // peaks offset a tenth of a pixel either way and saddle/convex surfaces
        r.pk.col = 9'd17; r.pk.row = 9'd17;
        r.pk.v = '{0, 1000, 0, 1000, 2000, 2000, 0, 1000, 0};
        rows.insert(rows.size(), r);
        r.pk.v = '{0, 1000, 0, 2000, 2000, 1000, 0, 1000, 0};
        rows.insert(rows.size(), r);
        r.pk.v = '{5000, 0, 5000, 0, -5000, 0, 5000, 0, 5000};
        rows.insert(rows.size(), r);
        r.pk.v = '{-9000, 0, 9000, 0, 1000, 0, 9000, 0, -9000};
        rows.insert(rows.size(), r);
        r.pk.v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        rows.insert(rows.size(), r);
        r.pk.v = '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, 32767, -32768};
        rows.insert(rows.size(), r);
        foreach (rows[i]) send_peak(rows[i].pk, rows[i].has_exp, rows[i].exp);
        drain();

        // Random phases across chip settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_chips(255, 255, 255, 255);
                1: set_chips(1, 1, 255, 255);
                2: set_chips(0, 0, 0, 0);
                3: set_chips(31, 3, 9, 21);
                4: set_chips(11, 11, 25, 25);
                5: set_chips(3, 5, 41, 17);
                6: set_chips(201, 255, 255, 211);
                default: set_chips(1, 1, 3, 3);
            endcase
            send_idle_pct = phase_idle[ph % 4];
            recv_stall_pct = phase_stall[ph % 4];
            fork
                if (ph == 4) begin
                    @(negedge i_clk);
                    hold_off = 1'b1;
                    repeat (300) @(negedge i_clk);
                    hold_off = 1'b0;
                end
                for (int n = 0; n < 200; n++)
                    send_peak(gen_peak($urandom_range(9) < 8), 1'b0, none);
            join
            drain();
        end

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/spr_pkg.sv
rtl/spr_in_if.sv
rtl/spr_out_if.sv
rtl/spr_fit.sv
rtl/spr_div.sv
rtl/ncc_subpixel_peak_refine_top.sv
dv/tb_ncc_subpixel_peak_refine_top.sv
